@@ rtl/bdcr_pkg.sv @@
package bdcr_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH    = 2'd2;

	localparam int unsigned STRENGTH_W = 10;
	localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 10'd256;

	// Mode codes.
	localparam logic MODE_WEBSAFE = 1'b0;
	localparam logic MODE_VGA     = 1'b1;
	localparam logic MATRIX_8X8   = 1'b0;
	localparam logic MATRIX_4X4   = 1'b1;

	typedef logic signed [6:0]  offset_t;   // D, offset is D/64
	typedef logic signed [16:0] scaled_t;   // D * strength
	typedef logic signed [23:0] ws_sum_t;   // web-safe sum in 1/16384 units
	typedef logic signed [17:0] vga_sum_t;  // VGA sum in 1/256 units
	typedef logic [18:0]        wsq_t;      // weighted squared difference
	typedef logic [19:0]        dist_t;     // palette distance
	typedef logic [3:0]         pal_idx_t;

	// 8x8 Bayer matrix, indexed by {row, column}.
	localparam logic [5:0] DITH8 [64] = '{
		6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
		6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
		6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
		6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
		6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
		6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
		6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
		6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
	};

	// 4x4 Bayer matrix, indexed by {row, column}.
	localparam logic [3:0] DITH4 [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	// Palette entries as {red, green, blue} level codes.
	localparam logic [5:0] PAL_CODE [16] = '{
		6'b00_00_00, 6'b01_00_00, 6'b00_01_00, 6'b01_01_00,
		6'b00_00_01, 6'b01_00_01, 6'b00_01_01, 6'b10_10_10,
		6'b01_01_01, 6'b11_00_00, 6'b00_11_00, 6'b11_11_00,
		6'b00_00_11, 6'b11_00_11, 6'b00_11_11, 6'b11_11_11
	};

	// Web-safe level k is reached when N >= (2k-1) * 51 * 8192.
	localparam ws_sum_t WS_TH [5] = '{
		24'sd417792, 24'sd1253376, 24'sd2088960, 24'sd2924544, 24'sd3760128
	};

	// Per-channel weights of the palette distance: red, green, blue.
	localparam logic [2:0] CHAN_WEIGHT [3] = '{3'd3, 3'd6, 3'd1};

	// Channel value of a palette level code.
	function automatic logic [7:0] level_value(input logic [1:0] code);
		logic [7:0] v;
		case (code)
			2'd0: v = 8'd0;
			2'd1: v = 8'd128;
			2'd2: v = 8'd192;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

	// Channel value of a web-safe level.
	function automatic logic [7:0] ws_value(input logic [2:0] level);
		logic [7:0] v;
		case (level)
			3'd0: v = 8'd0;
			3'd1: v = 8'd51;
			3'd2: v = 8'd102;
			3'd3: v = 8'd153;
			3'd4: v = 8'd204;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/bayer_dither_color_reduce.sv @@
// Ordered Bayer dither with color reduction to web-safe or 16-color VGA.
//
// Pixel input: pixel_valid/pixel_ready with red_in, green_in, blue_in and the
// Bayer column_phase/row_phase. Result output: result_valid/result_ready with
// red_out, green_out, blue_out. An item moves at a clock edge where valid and
// ready are both high.
// Configuration: cfg_write_enable writes cfg_data to register cfg_index
// (0 color_mode, 1 matrix_size, 2 dither_strength) at once; index 3 is
// ignored. Write only while no item is in flight.
// The pipeline has seven register stages (offset scaling, sums, quantize,
// squares, distances and a two-level registered minimum search), so one item
// enters every cycle unless all stages hold an item and the receiver stalls.
// When the receiver stalls, each stage holds its item and empty stages keep
// filling; pixel_ready drops only once all seven stages hold an item.
// Reset clears all stage valid bits and returns the registers to web-safe
// mode, 8x8 matrix and strength 256.
module bayer_dither_color_reduce
	import bdcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_enable,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [STRENGTH_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	input  logic [2:0]            column_phase,
	input  logic [2:0]            row_phase,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out
);

	// Configuration registers.
	logic                  color_mode_q;
	logic                  matrix_size_q;
	logic [STRENGTH_W-1:0] strength_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q  <= MODE_WEBSAFE;
			matrix_size_q <= MATRIX_8X8;
			strength_q    <= STRENGTH_RESET;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				CFG_COLOR_MODE:  color_mode_q  <= cfg_data[0];
				CFG_MATRIX_SIZE: matrix_size_q <= cfg_data[0];
				CFG_STRENGTH:    strength_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valid bits and per-stage load enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !valid_s7 || result_ready;
	assign en6 = !valid_s6 || en7;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pixel_ready  = en1;
	assign result_valid = valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pixel_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
		end
	end

	// Stage 1: Bayer lookup, centered offset and strength scaling.
	logic [5:0] b8;
	logic [3:0] b4;
	offset_t    d_off;
	scaled_t    ds;

	assign b8 = DITH8[{row_phase, column_phase}];
	assign b4 = DITH4[{row_phase[1:0], column_phase[1:0]}];
	assign d_off = (matrix_size_q == MATRIX_8X8) ? ($signed({1'b0, b8}) - 7'sd32)
		: ($signed({1'b0, b4, 2'b00}) - 7'sd32);
	assign ds = scaled_t'(d_off) * scaled_t'($signed({1'b0, strength_q}));

	logic [7:0] chan_s1 [3];
	scaled_t    ds_s1;
	logic       mode_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			chan_s1[0] <= red_in;
			chan_s1[1] <= green_in;
			chan_s1[2] <= blue_in;
			ds_s1      <= ds;
			mode_s1    <= color_mode_q;
		end
	end

	// Stage 2: per-channel sums for both modes.
	ws_sum_t  dse;
	ws_sum_t  ds51;
	vga_sum_t dsv;
	ws_sum_t  ws_sum_s2 [3];
	vga_sum_t vga_sum_s2 [3];
	logic     mode_s2;

	assign dse  = {{7{ds_s1[16]}}, ds_s1};
	assign ds51 = (dse <<< 5) + (dse <<< 4) + (dse <<< 1) + dse;
	assign dsv  = {ds_s1[16], ds_s1};

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int c = 0; c < 3; c++) begin
				ws_sum_s2[c]  <= $signed({2'b00, chan_s1[c], 14'd0}) + ds51;
				vga_sum_s2[c] <= $signed({2'b00, chan_s1[c], 8'd0}) + dsv;
			end
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: web-safe level count and VGA floor with clamp.
	logic [7:0] ws_s3 [3];
	logic [7:0] q_s3 [3];
	logic       mode_s3;
	logic [2:0] level [3];
	logic [7:0] qv [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			level[c] = 3'd0;
			for (int k = 0; k < 5; k++) begin
				level[c] = level[c] + {2'b00, (ws_sum_s2[c] >= WS_TH[k])};
			end
			if (vga_sum_s2[c][17]) begin
				qv[c] = 8'd0;
			end else if (vga_sum_s2[c][16]) begin
				qv[c] = 8'd255;
			end else begin
				qv[c] = vga_sum_s2[c][15:8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int c = 0; c < 3; c++) begin
				ws_s3[c] <= ws_value(level[c]);
				q_s3[c]  <= qv[c];
			end
			mode_s3 <= mode_s2;
		end
	end

	// Stage 4: weighted squared difference to each palette level, per channel.
	logic [7:0]  adiff [3][4];
	logic [15:0] sq [3][4];
	wsq_t        wsq_s4 [3][4];
	logic [7:0]  ws_s4 [3];
	logic        mode_s4;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 4; k++) begin
				if (q_s3[c] >= level_value(2'(k))) begin
					adiff[c][k] = q_s3[c] - level_value(2'(k));
				end else begin
					adiff[c][k] = level_value(2'(k)) - q_s3[c];
				end
				sq[c][k] = adiff[c][k] * adiff[c][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 4; k++) begin
					wsq_s4[c][k] <= wsq_t'(sq[c][k]) * wsq_t'(CHAN_WEIGHT[c]);
				end
			end
			ws_s4   <= ws_s3;
			mode_s4 <= mode_s3;
		end
	end

	// Stage 5: distance of every palette entry.
	dist_t      dist_s5 [16];
	logic [7:0] ws_s5 [3];
	logic       mode_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int i = 0; i < 16; i++) begin
				dist_s5[i] <= dist_t'(wsq_s4[0][PAL_CODE[i][5:4]])
					+ dist_t'(wsq_s4[1][PAL_CODE[i][3:2]])
					+ dist_t'(wsq_s4[2][PAL_CODE[i][1:0]]);
			end
			ws_s5   <= ws_s4;
			mode_s5 <= mode_s4;
		end
	end

	// Stage 6: best entry in each group of four; the lower index keeps a tie.
	pal_idx_t   grp_idx [4];
	dist_t      grp_dist [4];
	pal_idx_t   best_idx_s6 [4];
	dist_t      grp_min_s6 [4];
	logic [7:0] ws_s6 [3];
	logic       mode_s6;

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			grp_idx[g]  = pal_idx_t'(4 * g);
			grp_dist[g] = dist_s5[4 * g];
			for (int j = 1; j < 4; j++) begin
				if (dist_s5[4 * g + j] < grp_dist[g]) begin
					grp_dist[g] = dist_s5[4 * g + j];
					grp_idx[g]  = pal_idx_t'(4 * g + j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			best_idx_s6 <= grp_idx;
			grp_min_s6  <= grp_dist;
			ws_s6       <= ws_s5;
			mode_s6     <= mode_s5;
		end
	end

	// Stage 7: final choice among the four groups and the output register.
	pal_idx_t fin_idx;
	dist_t    fin_dist;
	logic     mode_s7;

	always_comb begin
		fin_idx  = best_idx_s6[0];
		fin_dist = grp_min_s6[0];
		for (int g = 1; g < 4; g++) begin
			if (grp_min_s6[g] < fin_dist) begin
				fin_dist = grp_min_s6[g];
				fin_idx  = best_idx_s6[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			if (mode_s6 == MODE_VGA) begin
				red_out   <= level_value(PAL_CODE[fin_idx][5:4]);
				green_out <= level_value(PAL_CODE[fin_idx][3:2]);
				blue_out  <= level_value(PAL_CODE[fin_idx][1:0]);
			end else begin
				red_out   <= ws_s6[0];
				green_out <= ws_s6[1];
				blue_out  <= ws_s6[2];
			end
			mode_s7 <= mode_s6;
		end
	end

	// The input side stalls only when every stage holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4
			&& valid_s5 && valid_s6 && valid_s7))
		else $error("pixel_ready low with an empty stage");

	// An accepted item always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> valid_s1)
		else $error("accepted item lost at stage 1");

	// VGA results are palette channel values.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mode_s7 == MODE_VGA |->
			(red_out == 8'd0 || red_out == 8'd128 || red_out == 8'd192
				|| red_out == 8'd255)
			&& (green_out == 8'd0 || green_out == 8'd128 || green_out == 8'd192
				|| green_out == 8'd255)
			&& (blue_out == 8'd0 || blue_out == 8'd128 || blue_out == 8'd192
				|| blue_out == 8'd255))
		else $error("VGA result is not a palette color");

	// Web-safe results are one of the six levels; red stands for all channels.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mode_s7 == MODE_WEBSAFE |->
			(red_out == 8'd0 || red_out == 8'd51 || red_out == 8'd102
				|| red_out == 8'd153 || red_out == 8'd204 || red_out == 8'd255))
		else $error("web-safe result is not a web-safe level");

endmodule

@@ bench/tb.sv @@
module tb;
	import bdcr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BLOCKS_PER_PHASE = 6;
	localparam int PIXELS_PER_BLOCK = 64;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] col;
		logic [2:0] row;
	} pixel_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// One directed case: register setting, pixel, and a hand-computed color where known.
	typedef struct packed {
		logic                  mode;
		logic                  matrix;
		logic [STRENGTH_W-1:0] strength;
		pixel_t                px;
		logic                  known;
		rgb_t                  want;
	} directed_row_t;

	// Threshold matrices, indexed by {row, column}.
	localparam int BAYER8 [64] = '{
		0, 48, 12, 60,  3, 51, 15, 63,
		32, 16, 44, 28, 35, 19, 47, 31,
		8, 56,  4, 52, 11, 59,  7, 55,
		40, 24, 36, 20, 43, 27, 39, 23,
		2, 50, 14, 62,  1, 49, 13, 61,
		34, 18, 46, 30, 33, 17, 45, 29,
		10, 58,  6, 54,  9, 57,  5, 53,
		42, 26, 38, 22, 41, 25, 37, 21
	};
	localparam int BAYER4 [16] = '{
		0,  8,  2, 10,
		12,  4, 14,  6,
		3, 11,  1,  9,
		15,  7, 13,  5
	};

	// The 16-color VGA palette as 24-bit RGB.
	localparam logic [23:0] PALETTE [16] = '{
		24'h000000, 24'h800000, 24'h008000, 24'h808000,
		24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
		24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
		24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
	};

	localparam int NUM_DIRECTED = 22;
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		// Reset setting: black stays black, white lands exactly on the top tie.
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd256, '{8'd0, 8'd0, 8'd0, 3'd0, 3'd0},
			1'b1, '{8'd0, 8'd0, 8'd0}},
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd256, '{8'd255, 8'd255, 8'd255, 3'd0, 3'd0},
			1'b1, '{8'd255, 8'd255, 8'd255}},
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd256, '{8'd128, 8'd64, 8'd200, 3'd3, 3'd5},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd256, '{8'd255, 8'd0, 8'd255, 3'd7, 3'd7},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		// Strength 512: a sum exactly halfway between two levels rounds up.
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd512, '{8'd0, 8'd0, 8'd0, 3'd1, 3'd0},
			1'b1, '{8'd51, 8'd51, 8'd51}},
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd512, '{8'd255, 8'd255, 8'd255, 3'd0, 3'd0},
			1'b1, '{8'd204, 8'd204, 8'd204}},
		// No dither: plain rounding to six levels.
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd0, '{8'd0, 8'd128, 8'd255, 3'd5, 3'd2},
			1'b1, '{8'd0, 8'd153, 8'd255}},
		'{MODE_WEBSAFE, MATRIX_8X8, 10'd0, '{8'd25, 8'd26, 8'd77, 3'd0, 3'd0},
			1'b1, '{8'd0, 8'd51, 8'd102}},
		// 4x4 matrix, mostly with the upper phase bits set, strength beyond 512.
		'{MODE_WEBSAFE, MATRIX_4X4, 10'd1023, '{8'd100, 8'd150, 8'd200, 3'd6, 3'd7},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MODE_WEBSAFE, MATRIX_4X4, 10'd1023, '{8'd0, 8'd255, 8'd7, 3'd4, 3'd4},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MODE_WEBSAFE, MATRIX_4X4, 10'd1023, '{8'd255, 8'd255, 8'd255, 3'd3, 3'd3},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		// VGA without dither: exact palette hits and the lowest-index tie.
		'{MODE_VGA, MATRIX_8X8, 10'd0, '{8'd192, 8'd192, 8'd192, 3'd2, 3'd2},
			1'b1, '{8'd192, 8'd192, 8'd192}},
		'{MODE_VGA, MATRIX_8X8, 10'd0, '{8'd128, 8'd128, 8'd128, 3'd1, 3'd6},
			1'b1, '{8'd128, 8'd128, 8'd128}},
		'{MODE_VGA, MATRIX_8X8, 10'd0, '{8'd64, 8'd0, 8'd0, 3'd0, 3'd0},
			1'b1, '{8'd0, 8'd0, 8'd0}},
		'{MODE_VGA, MATRIX_8X8, 10'd0, '{8'd65, 8'd0, 8'd0, 3'd0, 3'd0},
			1'b1, '{8'd128, 8'd0, 8'd0}},
		'{MODE_VGA, MATRIX_8X8, 10'd0, '{8'd255, 8'd0, 8'd0, 3'd4, 3'd1},
			1'b1, '{8'd255, 8'd0, 8'd0}},
		// VGA at full strength: negative sum clamps to zero, large sum saturates.
		'{MODE_VGA, MATRIX_8X8, 10'd1023, '{8'd10, 8'd10, 8'd10, 3'd0, 3'd0},
			1'b1, '{8'd0, 8'd0, 8'd0}},
		'{MODE_VGA, MATRIX_8X8, 10'd1023, '{8'd255, 8'd255, 8'd255, 3'd7, 3'd0},
			1'b1, '{8'd255, 8'd255, 8'd255}},
		'{MODE_VGA, MATRIX_8X8, 10'd1023, '{8'd200, 8'd30, 8'd90, 3'd4, 3'd6},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MODE_VGA, MATRIX_4X4, 10'd300, '{8'd160, 8'd160, 8'd100, 3'd5, 3'd6},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MODE_VGA, MATRIX_4X4, 10'd300, '{8'd0, 8'd255, 8'd128, 3'd7, 3'd3},
			1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MODE_VGA, MATRIX_4X4, 10'd512, '{8'd255, 8'd255, 8'd255, 3'd0, 3'd0},
			1'b0, '{8'd0, 8'd0, 8'd0}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write_enable = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [STRENGTH_W-1:0] cfg_data = '0;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_ready;
	logic [7:0]            red_in = '0;
	logic [7:0]            green_in = '0;
	logic [7:0]            blue_in = '0;
	logic [2:0]            column_phase = '0;
	logic [2:0]            row_phase = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;

	// Register values as the block should hold them.
	logic                  cur_mode = MODE_WEBSAFE;
	logic                  cur_matrix = MATRIX_8X8;
	logic [STRENGTH_W-1:0] cur_strength = STRENGTH_RESET;

	rgb_t pending_colors [$];
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   errors = 0;
	int   pixels_sent = 0;
	int   results_seen = 0;
	int   settings_used = 1;

	bayer_dither_color_reduce uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.pixel_valid      (pixel_valid),
		.pixel_ready      (pixel_ready),
		.red_in           (red_in),
		.green_in         (green_in),
		.blue_in          (blue_in),
		.column_phase     (column_phase),
		.row_phase        (row_phase),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.red_out          (red_out),
		.green_out        (green_out),
		.blue_out         (blue_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Dithered and color-reduced pixel for a given register setting.
	function automatic rgb_t reduce_pixel(input pixel_t px, input logic mode,
			input logic matrix, input logic [STRENGTH_W-1:0] strength);
		int d;
		int s;
		int n;
		int lvl;
		int t;
		int dr;
		int dg;
		int db;
		int err;
		int min_err;
		int best;
		int k;
		int i;
		int chan_in [3];
		int chan_q [3];
		logic [23:0] pc;
		rgb_t res;
		s = int'(strength);
		chan_in[0] = int'(px.red);
		chan_in[1] = int'(px.green);
		chan_in[2] = int'(px.blue);
		if (matrix == MATRIX_8X8) begin
			d = BAYER8[{px.row, px.col}] - 32;
		end else begin
			d = 4 * (BAYER4[{px.row[1:0], px.col[1:0]}] - 8);
		end
		for (k = 0; k < 3; k++) begin
			if (mode == MODE_WEBSAFE) begin
				// Sum in 1/16384 units, clamped, then rounded half up to six levels.
				n = chan_in[k] * 16384 + d * 51 * s;
				if (n < 0) n = 0;
				if (n > 255 * 16384) n = 255 * 16384;
				lvl = (2 * n + 51 * 16384) / (102 * 16384);
				if (lvl > 5) lvl = 5;
				chan_q[k] = lvl * 51;
			end else begin
				// Sum in 1/256 units, floored and clamped.
				t = chan_in[k] * 256 + d * s;
				if (t < 0) begin
					chan_q[k] = 0;
				end else begin
					chan_q[k] = (t / 256 > 255) ? 255 : t / 256;
				end
			end
		end
		if (mode == MODE_WEBSAFE) begin
			res.r = chan_q[0][7:0];
			res.g = chan_q[1][7:0];
			res.b = chan_q[2][7:0];
		end else begin
			// Nearest palette entry by weighted distance; strict compare keeps the lowest index.
			min_err = 32'h7fffffff;
			best = 0;
			for (i = 0; i < 16; i++) begin
				pc = PALETTE[i];
				dr = chan_q[0] - int'(pc[23:16]);
				dg = chan_q[1] - int'(pc[15:8]);
				db = chan_q[2] - int'(pc[7:0]);
				err = 3 * dr * dr + 6 * dg * dg + db * db;
				if (err < min_err) begin
					min_err = err;
					best = i;
				end
			end
			res = PALETTE[best];
		end
		return res;
	endfunction

	function automatic logic [7:0] random_channel();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return 8'd0;
		if (pick == 1) return 8'd255;
		return 8'($urandom);
	endfunction

	// Stop sending and wait until every expected color has come back.
	task automatic wait_for_drain();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	// Offer one pixel, hold it until accepted, then queue its expected color.
	task automatic send_pixel(input pixel_t px, input rgb_t color);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid  <= 1'b1;
		red_in       <= px.red;
		green_in     <= px.green;
		blue_in      <= px.blue;
		column_phase <= px.col;
		row_phase    <= px.row;
		do @(posedge clk); while (!pixel_ready);
		pending_colors.push_back(color);
		pixels_sent++;
	endtask

	// Write all registers while the pipeline is empty; index 3 gets junk and must be ignored.
	task automatic set_config(input logic mode, input logic matrix,
			input logic [STRENGTH_W-1:0] strength);
		logic [8:0] junk;
		wait_for_drain();
		repeat (10) @(posedge clk);
		junk = 9'($urandom);
		cfg_write_enable <= 1'b1;
		cfg_index        <= CFG_COLOR_MODE;
		cfg_data         <= {junk, mode};
		@(posedge clk);
		junk = 9'($urandom);
		cfg_index <= CFG_MATRIX_SIZE;
		cfg_data  <= {junk, matrix};
		@(posedge clk);
		cfg_index <= CFG_STRENGTH;
		cfg_data  <= strength;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data  <= STRENGTH_W'($urandom);
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		@(posedge clk);
		cur_mode     = mode;
		cur_matrix   = matrix;
		cur_strength = strength;
		settings_used++;
	endtask

	// Result side: random stalls and comparison against the oldest expectation.
	always @(posedge clk) begin
		rgb_t want;
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected result %0d %0d %0d", $time,
					red_out, green_out, blue_out);
				errors++;
			end else begin
				want = pending_colors.pop_front();
				if (red_out !== want.r) begin
					$display("%0t: red_out expected %0d, got %0d", $time, want.r, red_out);
					errors++;
				end
				if (green_out !== want.g) begin
					$display("%0t: green_out expected %0d, got %0d", $time, want.g,
						green_out);
					errors++;
				end
				if (blue_out !== want.b) begin
					$display("%0t: blue_out expected %0d, got %0d", $time, want.b,
						blue_out);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb failed");
		$finish;
	end

	// Main sequence: reset, directed cases, then three phases of random pixels.
	initial begin
		pixel_t px;
		rgb_t color;
		logic mode;
		logic matrix;
		logic [STRENGTH_W-1:0] strength;
		int row;
		int phase;
		int blk;
		int i;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 48;
		for (row = 0; row < NUM_DIRECTED; row++) begin
			if (DIRECTED[row].mode != cur_mode || DIRECTED[row].matrix != cur_matrix ||
					DIRECTED[row].strength != cur_strength) begin
				set_config(DIRECTED[row].mode, DIRECTED[row].matrix,
					DIRECTED[row].strength);
			end
			px = DIRECTED[row].px;
			if (DIRECTED[row].known) begin
				color = DIRECTED[row].want;
			end else begin
				color = reduce_pixel(px, cur_mode, cur_matrix, cur_strength);
			end
			send_pixel(px, color);
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
				// The first blocks walk all mode and matrix pairs and the strength extremes.
				if (blk < 4) begin
					mode   = blk[0];
					matrix = blk[1];
				end else begin
					mode   = 1'($urandom);
					matrix = 1'($urandom);
				end
				case (blk == 0 ? 2 : (blk == 1 ? 0 : $urandom_range(5)))
					0: strength = 10'd0;
					1: strength = 10'd512;
					2: strength = 10'd1023;
					3: strength = STRENGTH_RESET;
					4: strength = STRENGTH_W'($urandom);
					default: strength = STRENGTH_W'($urandom_range(512));
				endcase
				set_config(mode, matrix, strength);
				for (i = 0; i < PIXELS_PER_BLOCK; i++) begin
					if ($urandom_range(199) == 0) wait_for_drain();
					px.red   = random_channel();
					px.green = random_channel();
					px.blue  = random_channel();
					px.col   = 3'($urandom);
					px.row   = 3'($urandom);
					send_pixel(px, reduce_pixel(px, cur_mode, cur_matrix, cur_strength));
				end
			end
		end

		wait_for_drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d pixels and checked %0d results over %0d register settings,",
			pixels_sent, results_seen, settings_used);
		$display("covering web-safe and VGA modes, both matrices and strengths 0 to 1023.");
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bdcr_pkg.sv
rtl/bayer_dither_color_reduce.sv
bench/tb.sv
